FILE: hw/rtl/frp_pkg.sv
`timescale 1ns / 1ps

package frp_pkg;

	localparam int unsigned DATA_W  = 64;
	localparam int unsigned CNT_W   = 15;
	localparam int unsigned TOTAL_W = 64;
	localparam int unsigned FSZ_W   = 4;
	localparam int unsigned BYTES   = DATA_W / 8;

	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_PUBLISH = 2'd1,
		KIND_PULL    = 2'd2,
		KIND_STOP    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_READY   = 3'd0,
		PH_RUNNING = 3'd1,
		PH_DRAINED = 3'd2,
		PH_STOPPED = 3'd3,
		PH_FAILED  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		RS_NONE     = 2'd0,
		RS_STOP     = 2'd1,
		RS_UNDERRUN = 2'd2
	} reason_t;

	typedef enum logic [1:0] {
		CFG_FRAME_SIZE   = 2'd0,
		CFG_RING_FRAMES  = 2'd1,
		CFG_TOTAL_FRAMES = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [CNT_W-1:0]   cap;
		logic [TOTAL_W-1:0] total;
		logic [DATA_W-1:0]  mask;
	} frp_cfg_t;

endpackage

FILE: hw/rtl/frp_ram.sv
`timescale 1ns / 1ps

module frp_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/frp_ctrl.sv
`timescale 1ns / 1ps

module frp_ctrl
	import frp_pkg::*;
#(
	parameter int unsigned RING_DEPTH = 4096,
	localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  frp_cfg_t            cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          kind,
	input  logic [DATA_W-1:0]   frame_data,
	input  logic                last_in_callback,
	input  logic [1:0]          stop_cause,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                given,
	output logic                accepted,
	output logic [2:0]          phase_now,
	output logic [1:0]          reason_now,
	output logic [CNT_W-1:0]    frames_queued,
	output logic [TOTAL_W-1:0]  zero_slots,
	output logic [TOTAL_W-1:0]  callback_count,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output logic [DATA_W-1:0]   mem_wdata,
	output logic                mem_re,
	output logic [AW-1:0]       mem_raddr
);

	phase_t             phase_q, phase_d;
	reason_t            reason_q, reason_d;
	logic [TOTAL_W-1:0] wr_total_q, rd_total_q, zero_q, cb_q;
	logic [CNT_W-1:0]   count_q;
	logic [AW-1:0]      wptr_q, rptr_q;
	logic               valid_q, given_q, acc_q;
	logic               take;
	logic               do_pub, do_read, do_zero, acc_d;
	logic [CNT_W-1:0]   cap_m1;
	logic [TOTAL_W-1:0] rd_next;

	assign in_stall = valid_q && out_stall;
	assign take     = in_valid && !in_stall;
	assign cap_m1   = cfg.cap - CNT_W'(1);
	assign rd_next  = rd_total_q + TOTAL_W'(1);

	always_comb begin
		phase_d  = phase_q;
		reason_d = reason_q;
		do_pub   = 1'b0;
		do_read  = 1'b0;
		do_zero  = 1'b0;
		acc_d    = 1'b0;
		unique case (kind_t'(kind))
			KIND_START: begin
				if (reason_q == RS_NONE && phase_q == PH_READY) begin
					phase_d = PH_RUNNING;
					acc_d   = 1'b1;
				end
			end
			KIND_PUBLISH: begin
				if (reason_q == RS_NONE && (phase_q == PH_READY || phase_q == PH_RUNNING)
						&& count_q < cfg.cap && wr_total_q < cfg.total) begin
					do_pub = 1'b1;
					acc_d  = 1'b1;
				end
			end
			KIND_PULL: begin
				do_zero = 1'b1;
				if (phase_q == PH_RUNNING) begin
					priority if (reason_q != RS_NONE) begin
						phase_d = (reason_q == RS_STOP) ? PH_STOPPED : PH_FAILED;
					end else if (rd_total_q >= cfg.total) begin
						phase_d = PH_DRAINED;
					end else if (count_q == '0) begin
						reason_d = RS_UNDERRUN;
						phase_d  = PH_FAILED;
					end else begin
						do_read = 1'b1;
						do_zero = 1'b0;
						if (rd_next == cfg.total) begin
							phase_d = PH_DRAINED;
						end
					end
				end
			end
			KIND_STOP: begin
				if ((stop_cause == RS_STOP || stop_cause == RS_UNDERRUN)
						&& reason_q == RS_NONE) begin
					reason_d = reason_t'(stop_cause);
					acc_d    = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign mem_we    = take && do_pub;
	assign mem_waddr = wptr_q;
	assign mem_wdata = frame_data & cfg.mask;
	assign mem_re    = take && do_read;
	assign mem_raddr = rptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_READY;
			reason_q   <= RS_NONE;
			wr_total_q <= '0;
			rd_total_q <= '0;
			zero_q     <= '0;
			cb_q       <= '0;
			count_q    <= '0;
			wptr_q     <= '0;
			rptr_q     <= '0;
			valid_q    <= 1'b0;
			given_q    <= 1'b0;
			acc_q      <= 1'b0;
		end else begin
			if (take) begin
				valid_q  <= 1'b1;
				given_q  <= do_read;
				acc_q    <= acc_d;
				phase_q  <= phase_d;
				reason_q <= reason_d;
				if (do_pub) begin
					wr_total_q <= wr_total_q + TOTAL_W'(1);
					wptr_q     <= ({{(CNT_W-AW){1'b0}}, wptr_q} >= cap_m1) ? '0 :
						wptr_q + AW'(1);
				end
				if (do_read) begin
					rd_total_q <= rd_next;
					rptr_q     <= ({{(CNT_W-AW){1'b0}}, rptr_q} >= cap_m1) ? '0 :
						rptr_q + AW'(1);
				end
				if (do_pub) begin
					count_q <= count_q + CNT_W'(1);
				end else if (do_read) begin
					count_q <= count_q - CNT_W'(1);
				end
				if (do_zero) begin
					zero_q <= zero_q + TOTAL_W'(1);
				end
				if (kind_t'(kind) == KIND_PULL && last_in_callback) begin
					cb_q <= cb_q + TOTAL_W'(1);
				end
			end else if (valid_q && !out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = valid_q;
	assign given          = given_q;
	assign accepted       = acc_q;
	assign phase_now      = phase_q;
	assign reason_now     = reason_q;
	assign frames_queued  = count_q;
	assign zero_slots     = zero_q;
	assign callback_count = cb_q;

endmodule

FILE: hw/rtl/frame_ring_pump_core.sv
`timescale 1ns / 1ps

// Frame ring with a run lifecycle (ready, running, drained, stopped, failed).
// Input channel: in_valid / in_stall carries one item: kind selects start,
// publish, pull or stop; frame_data, last_in_callback and stop_cause go with it.
// Output channel: out_valid / out_stall returns exactly one result per item.
// Configuration: wr_en / wr_index / wr_data, taken at any clock edge with wr_en;
// write it only while no item is in flight.
// Latency: a result is presented the cycle after its item transfers.
// Throughput: one item per cycle while no result waits under out_stall; publish
// writes and pull reads each use one port of the frame memory, whose registered
// read data goes straight into the output.
// While a result waits under out_stall, in_stall is raised and no item is taken.
// Reset clears phase, reason, pointers, counters and configuration defaults;
// the frame memory is not cleared, nothing is read before it is written.
module frame_ring_pump_core
	import frp_pkg::*;
#(
	parameter int unsigned RING_DEPTH = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [TOTAL_W-1:0]  wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          kind,
	input  logic [DATA_W-1:0]   frame_data,
	input  logic                last_in_callback,
	input  logic [1:0]          stop_cause,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [DATA_W-1:0]   out_frame,
	output logic                from_ring,
	output logic                accepted,
	output logic [2:0]          phase_now,
	output logic [1:0]          reason_now,
	output logic [CNT_W-1:0]    frames_queued,
	output logic [TOTAL_W-1:0]  zero_slots,
	output logic [TOTAL_W-1:0]  callback_count
);

	localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	logic [FSZ_W-1:0]   fsz_q;
	logic [CNT_W-1:0]   ring_q;
	logic [TOTAL_W-1:0] total_q;
	logic [FSZ_W-1:0]   fsz_c;
	frp_cfg_t           cfg;
	logic               mem_we, mem_re, given;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [DATA_W-1:0]  mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsz_q   <= FSZ_W'(2);
			ring_q  <= CNT_W'(4096);
			total_q <= TOTAL_W'(1);
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				CFG_FRAME_SIZE:   fsz_q   <= wr_data[FSZ_W-1:0];
				CFG_RING_FRAMES:  ring_q  <= wr_data[CNT_W-1:0];
				CFG_TOTAL_FRAMES: total_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (fsz_q < FSZ_W'(2)) begin
			fsz_c = FSZ_W'(2);
		end else if (fsz_q > FSZ_W'(BYTES)) begin
			fsz_c = FSZ_W'(BYTES);
		end else begin
			fsz_c = fsz_q;
		end
		for (int i = 0; i < BYTES; i++) begin
			cfg.mask[i*8 +: 8] = (FSZ_W'(i) < fsz_c) ? 8'hFF : 8'h00;
		end
		priority if (ring_q == '0) begin
			cfg.cap = CNT_W'(1);
		end else if (ring_q > CNT_W'(RING_DEPTH)) begin
			cfg.cap = CNT_W'(RING_DEPTH);
		end else begin
			cfg.cap = ring_q;
		end
		cfg.total = total_q;
	end

	frp_ctrl #(
		.RING_DEPTH(RING_DEPTH)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.frame_data      (frame_data),
		.last_in_callback(last_in_callback),
		.stop_cause      (stop_cause),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.given           (given),
		.accepted        (accepted),
		.phase_now       (phase_now),
		.reason_now      (reason_now),
		.frames_queued   (frames_queued),
		.zero_slots      (zero_slots),
		.callback_count  (callback_count),
		.mem_we          (mem_we),
		.mem_waddr       (mem_waddr),
		.mem_wdata       (mem_wdata),
		.mem_re          (mem_re),
		.mem_raddr       (mem_raddr)
	);

	frp_ram #(
		.WIDTH(DATA_W),
		.DEPTH(RING_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign from_ring = given;
	assign out_frame = given ? mem_rdata : '0;

endmodule

FILE: tb/sv/frame_ring_pump_core_tb.sv
`timescale 1ns / 1ps

module frame_ring_pump_core_tb;
	import frp_pkg::*;

	localparam int unsigned RING_SLOTS  = 4096;
	localparam int unsigned SLOT_AW     = $clog2(RING_SLOTS);
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned RANDOM_ITEMS = 1150;
	localparam int unsigned LONG_HOLD   = 300;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] data;
		logic        last;
		logic [1:0]  cause;
	} pump_item_t;

	typedef struct packed {
		logic [63:0] frame;
		logic        given;
		logic        acc;
		phase_t      phase;
		reason_t     reason;
		logic [14:0] queued;
		logic [63:0] zeros;
		logic [63:0] callbacks;
	} pump_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              wr_en = 1'b0;
	logic [1:0]        wr_index = CFG_FRAME_SIZE;
	logic [63:0]       wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        kind = KIND_START;
	logic [63:0]       frame_data = '0;
	logic              last_in_callback = 1'b0;
	logic [1:0]        stop_cause = RS_NONE;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [63:0]       out_frame;
	logic              from_ring;
	logic              accepted;
	logic [2:0]        phase_now;
	logic [1:0]        reason_now;
	logic [14:0]       frames_queued;
	logic [63:0]       zero_slots;
	logic [63:0]       callback_count;

	frame_ring_pump_core #(.RING_DEPTH(RING_SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.frame_data(frame_data),
		.last_in_callback(last_in_callback),
		.stop_cause(stop_cause),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_frame(out_frame),
		.from_ring(from_ring),
		.accepted(accepted),
		.phase_now(phase_now),
		.reason_now(reason_now),
		.frames_queued(frames_queued),
		.zero_slots(zero_slots),
		.callback_count(callback_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mirror of the block state
	logic [3:0]   fsz_cfg = 4'd2;
	logic [14:0]  ring_sz = 15'd4096;
	logic [63:0]  total_cfg = 64'd1;
	logic [63:0]  frame_mirror [RING_SLOTS];
	logic [63:0]  wr_cnt = '0;
	logic [63:0]  rd_cnt = '0;
	phase_t       phase_q = PH_READY;
	reason_t      reason_q = RS_NONE;
	logic [63:0]  zero_cnt = '0;
	logic [63:0]  cb_cnt = '0;

	pump_item_t   pending [$];
	pump_result_t expected_results [$];
	int unsigned  n_pushed = 0;
	int unsigned  n_taken = 0;
	int unsigned  n_results = 0;
	int unsigned  errors = 0;
	int unsigned  ring_hits = 0;
	bit           hold_req = 1'b0;

	function automatic logic [63:0] ring_cap(logic [14:0] n);
		if (n == 0)
			return 64'd1;
		if (n > RING_SLOTS)
			return 64'(RING_SLOTS);
		return {49'd0, n};
	endfunction

	function automatic logic [63:0] frame_mask(logic [3:0] fsz);
		logic [3:0] b;
		b = (fsz < 2) ? 4'd2 : fsz;
		if (b >= 8)
			return '1;
		return (64'd1 << (8 * b)) - 64'd1;
	endfunction

	function automatic pump_result_t pump_predict(logic [1:0] k, logic [63:0] d, logic lst,
			logic [1:0] cause);
		pump_result_t r;
		logic [63:0]  cap;
		cap = ring_cap(ring_sz);
		r = '0;
		case (k)
			KIND_START: begin
				if (reason_q == RS_NONE && phase_q == PH_READY) begin
					phase_q = PH_RUNNING;
					r.acc = 1'b1;
				end
			end
			KIND_PUBLISH: begin
				if (reason_q == RS_NONE && (phase_q == PH_READY || phase_q == PH_RUNNING) &&
						wr_cnt - rd_cnt < cap && wr_cnt < total_cfg) begin
					frame_mirror[SLOT_AW'(wr_cnt % cap)] = d & frame_mask(fsz_cfg);
					wr_cnt = wr_cnt + 1;
					r.acc = 1'b1;
				end
			end
			KIND_PULL: begin
				if (lst)
					cb_cnt = cb_cnt + 1;
				if (phase_q == PH_RUNNING) begin
					if (reason_q != RS_NONE)
						phase_q = (reason_q == RS_STOP) ? PH_STOPPED : PH_FAILED;
					else if (rd_cnt >= total_cfg)
						phase_q = PH_DRAINED;
					else if (wr_cnt == rd_cnt) begin
						reason_q = RS_UNDERRUN;
						phase_q = PH_FAILED;
					end else begin
						r.frame = frame_mirror[SLOT_AW'(rd_cnt % cap)];
						r.given = 1'b1;
						rd_cnt = rd_cnt + 1;
						if (rd_cnt == total_cfg)
							phase_q = PH_DRAINED;
					end
				end
				if (!r.given)
					zero_cnt = zero_cnt + 1;
			end
			default: begin
				if ((cause == RS_STOP || cause == RS_UNDERRUN) && reason_q == RS_NONE) begin
					reason_q = reason_t'(cause);
					r.acc = 1'b1;
				end
			end
		endcase
		r.phase = phase_q;
		r.reason = reason_q;
		r.queued = 15'(wr_cnt - rd_cnt);
		r.zeros = zero_cnt;
		r.callbacks = cb_cnt;
		return r;
	endfunction

	// sender: bursts and gaps
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		pump_item_t it;
		if (arst_n && (!in_valid || !in_stall)) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending.size() != 0) begin
				it = pending.pop_front();
				in_valid <= 1'b1;
				kind <= it.kind;
				frame_data <= it.data;
				last_in_callback <= it.last;
				stop_cause <= it.cause;
				if (burst_left <= 1) begin
					if ($urandom_range(0, 7) == 0) begin
						burst_left = $urandom_range(100, 250);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = $urandom_range(0, 8);
					end
				end else
					burst_left--;
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver: stall pattern in modes, plus one long hold on request
	int unsigned hold_left = 0;
	int unsigned mode_left = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_tick = 0;

	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 200);
		end else
			mode_left--;
		stall_tick++;
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 7) == 0);
				2: out_stall <= 1'($urandom_range(0, 1));
				default: out_stall <= (stall_tick % 3 == 0);
			endcase
		end
	end

	// input side: config shadow and expectations
	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en) begin
				case (wr_index)
					CFG_FRAME_SIZE: fsz_cfg = wr_data[3:0];
					CFG_RING_FRAMES: ring_sz = wr_data[14:0];
					CFG_TOTAL_FRAMES: total_cfg = wr_data;
					default: ;
				endcase
			end
			if (in_valid && in_stall === 1'b0) begin
				expected_results.push_back(pump_predict(kind, frame_data, last_in_callback,
					stop_cause));
				n_taken++;
			end
		end
	end

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 50)
				$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// output side: compare against the oldest expectation
	always @(posedge clk) begin
		pump_result_t e;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			n_results++;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 50)
					$display("%0t: unexpected result transfer: expected none, actual frame %h",
						$time, out_frame);
			end else begin
				e = expected_results.pop_front();
				if (e.given)
					ring_hits++;
				check_field("out_frame", e.frame, out_frame);
				check_field("from_ring", 64'(e.given), 64'(from_ring));
				check_field("accepted", 64'(e.acc), 64'(accepted));
				check_field("phase_now", 64'(e.phase), 64'(phase_now));
				check_field("reason_now", 64'(e.reason), 64'(reason_now));
				check_field("frames_queued", 64'(e.queued), 64'(frames_queued));
				check_field("zero_slots", e.zeros, zero_slots);
				check_field("callback_count", e.callbacks, callback_count);
			end
		end
	end

	int unsigned quiet = 0;

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: watchdog expired with %0d results outstanding", $time,
				expected_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic push_item(logic [1:0] k, logic [63:0] d, logic lst, logic [1:0] cause);
		pump_item_t it;
		it.kind = k;
		it.data = d;
		it.last = lst;
		it.cause = cause;
		pending.push_back(it);
		n_pushed++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (n_taken != n_pushed || expected_results.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	initial begin
		int unsigned random_done;
		int unsigned phase_no;
		int unsigned n;
		int unsigned i;
		int unsigned r;
		int unsigned pub_pct;
		int unsigned ending;
		logic [63:0] depth;
		logic [63:0] cap;
		logic [63:0] d;
		logic [14:0] ring_val;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: one frame in the whole stream
		push_item(KIND_PULL, rnd64(), 1'b1, 2'($urandom));
		push_item(KIND_STOP, rnd64(), 1'b0, 2'd0);
		push_item(KIND_STOP, rnd64(), 1'b1, 2'd3);
		push_item(KIND_PUBLISH, '1, 1'b1, 2'd3);
		push_item(KIND_PUBLISH, 64'h1234, 1'b0, 2'd0);
		wait_idle();

		// frame size and ring size below range; ring of one is full
		write_reg(CFG_FRAME_SIZE, 64'd0);
		write_reg(CFG_RING_FRAMES, 64'd0);
		write_reg(CFG_TOTAL_FRAMES, '1);
		push_item(KIND_PUBLISH, rnd64(), 1'b0, 2'd1);
		push_item(KIND_START, rnd64(), 1'b1, 2'd2);
		push_item(KIND_START, rnd64(), 1'b0, 2'd1);
		push_item(KIND_PULL, rnd64(), 1'b0, 2'd1);
		push_item(KIND_PUBLISH, '1, 1'b0, 2'd2);
		push_item(KIND_PULL, '1, 1'b1, 2'd3);
		wait_idle();

		// frame size and ring size above range
		write_reg(CFG_FRAME_SIZE, 64'd15);
		write_reg(CFG_RING_FRAMES, 64'h7FFF);
		push_item(KIND_PUBLISH, '1, 1'b1, 2'd0);
		push_item(KIND_PUBLISH, 64'd0, 1'b0, 2'd3);
		push_item(KIND_PUBLISH, 64'h0123_4567_89AB_CDEF, 1'b1, 2'd1);
		push_item(KIND_PULL, '0, 1'b1, 2'd0);
		push_item(KIND_PULL, '1, 1'b0, 2'd3);
		push_item(KIND_PULL, '0, 1'b1, 2'd2);
		wait_idle();

		// zero total, then total below frames already written
		write_reg(CFG_TOTAL_FRAMES, 64'd0);
		push_item(KIND_PUBLISH, rnd64(), 1'b0, 2'd0);
		wait_idle();
		write_reg(CFG_TOTAL_FRAMES, 64'd2);
		push_item(KIND_PUBLISH, rnd64(), 1'b1, 2'd0);
		wait_idle();

		write_reg(CFG_TOTAL_FRAMES, '1);
		write_reg(CFG_FRAME_SIZE, 64'd8);
		write_reg(CFG_RING_FRAMES, 64'd16384);
		push_item(KIND_PUBLISH, 64'h8000_0000_0000_0001, 1'b0, 2'd0);
		push_item(KIND_PULL, rnd64(), 1'b0, 2'd0);
		wait_idle();
		write_reg(CFG_RING_FRAMES, 64'd1);
		push_item(KIND_PUBLISH, 64'hFEDC_BA98_7654_3210, 1'b0, 2'd0);
		push_item(KIND_PUBLISH, rnd64(), 1'b0, 2'd0);
		push_item(KIND_PULL, rnd64(), 1'b1, 2'd0);
		wait_idle();

		// random phases, ring drained at the end of each so its size can change
		random_done = 0;
		phase_no = 0;
		while (random_done < RANDOM_ITEMS) begin
			wait_idle();
			if ($urandom_range(0, 99) < 85)
				write_reg(CFG_FRAME_SIZE, 64'($urandom_range(2, 8)));
			else
				write_reg(CFG_FRAME_SIZE, 64'($urandom_range(0, 15)));
			r = $urandom_range(0, 99);
			if (r < 70)
				ring_val = 15'($urandom_range(1, 8));
			else if (r < 90)
				ring_val = 15'($urandom_range(9, 64));
			else begin
				case ($urandom_range(0, 4))
					0: ring_val = 15'd0;
					1: ring_val = 15'd4096;
					2: ring_val = 15'd4097;
					3: ring_val = 15'd16384;
					default: ring_val = 15'h7FFF;
				endcase
			end
			write_reg(CFG_RING_FRAMES, {49'd0, ring_val});
			if ($urandom_range(0, 1) == 0)
				write_reg(CFG_TOTAL_FRAMES, '1);
			else
				write_reg(CFG_TOTAL_FRAMES, {$urandom | 32'd1, $urandom});

			cap = ring_cap(ring_val);
			depth = wr_cnt - rd_cnt;
			pub_pct = $urandom_range(30, 60);
			n = $urandom_range(60, 140);
			for (i = 0; i < n; i++) begin
				r = $urandom_range(0, 99);
				case ($urandom_range(0, 9))
					0: d = '1;
					1: d = '0;
					default: d = rnd64();
				endcase
				if (r < 84 && (r < pub_pct || depth == 0)) begin
					push_item(KIND_PUBLISH, d, 1'($urandom), 2'($urandom));
					if (depth < cap)
						depth++;
				end else if (r < 84) begin
					push_item(KIND_PULL, d, 1'($urandom), 2'($urandom));
					depth--;
				end else if (r < 93)
					push_item(KIND_STOP, d, 1'($urandom), $urandom_range(0, 1) ? 2'd3 : 2'd0);
				else
					push_item(KIND_START, d, 1'($urandom), 2'($urandom));
			end
			random_done += n;
			for (; depth != 0; depth--) begin
				push_item(KIND_PULL, rnd64(), 1'($urandom), 2'($urandom));
				random_done++;
			end
			if (phase_no == 2)
				hold_req = 1'b1;
			phase_no++;
		end
		wait_idle();

		// one way out of the running phase
		ending = $urandom_range(0, 4);
		case (ending)
			0: begin
				push_item(KIND_STOP, rnd64(), 1'b0, RS_STOP);
				push_item(KIND_STOP, rnd64(), 1'b0, RS_UNDERRUN);
				push_item(KIND_PUBLISH, rnd64(), 1'b0, 2'd0);
				push_item(KIND_START, rnd64(), 1'b0, 2'd0);
				push_item(KIND_PULL, rnd64(), 1'b1, 2'd0);
			end
			1: begin
				push_item(KIND_STOP, rnd64(), 1'b0, RS_UNDERRUN);
				push_item(KIND_STOP, rnd64(), 1'b0, RS_STOP);
				push_item(KIND_PULL, rnd64(), 1'b0, 2'd0);
			end
			2: begin
				push_item(KIND_PUBLISH, rnd64(), 1'b0, 2'd0);
				push_item(KIND_PULL, rnd64(), 1'b0, 2'd0);
				push_item(KIND_PULL, rnd64(), 1'b1, 2'd0);
			end
			3: begin
				write_reg(CFG_TOTAL_FRAMES, wr_cnt + 64'd3);
				for (i = 0; i < 3; i++) begin
					push_item(KIND_PUBLISH, rnd64(), 1'b0, 2'd0);
					push_item(KIND_PULL, rnd64(), 1'($urandom), 2'd0);
				end
				push_item(KIND_PULL, rnd64(), 1'b1, 2'd0);
			end
			default: begin
				write_reg(CFG_TOTAL_FRAMES, 64'd0);
				push_item(KIND_PUBLISH, rnd64(), 1'b0, 2'd0);
				push_item(KIND_PULL, rnd64(), 1'b0, 2'd0);
			end
		endcase
		wait_idle();

		// anything after the end of the lifecycle
		for (i = 0; i < 40; i++)
			push_item(2'($urandom), rnd64(), 1'($urandom), 2'($urandom));
		wait_idle();
		repeat (5) @(posedge clk);

		$display("Run covered %0d item and %0d result transfers over %0d random phases, %s %0d",
			n_taken, n_results, phase_no, "ending case", ending);
		$display("%0d frames came from the ring, %0d zero-filled slots, final phase %0d reason %0d",
			ring_hits, zero_cnt, phase_q, reason_q);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: frame_ring_pump_core.f
hw/rtl/frp_pkg.sv
hw/rtl/frp_ram.sv
hw/rtl/frp_ctrl.sv
hw/rtl/frame_ring_pump_core.sv
tb/sv/frame_ring_pump_core_tb.sv
